>>> design/ccr_pkg.sv
`default_nettype none
package ccr_pkg;

  // coordinate and intermediate widths for 16-bit input fields
  localparam int CW = 16;          // coordinate
  localparam int DW = CW + 1;      // differences and sums
  localparam int PW = 2 * DW;      // first products
  localparam int EW = PW + 1;      // e and f
  localparam int GW = PW + 2;      // determinant g
  localparam int MW = DW + EW;     // second products
  localparam int NW = MW + 1;      // center numerators
  localparam int XW = NW + 2;      // signed quotient and point offset
  localparam int RW = 32;          // result fields
  localparam int QDEPTH = 4;       // job queue depth

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_COLIN = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  // signed 32-bit limits at quotient width
  localparam logic signed [XW-1:0] S32_MAX = XW'(64'sd2147483647);
  localparam logic signed [XW-1:0] S32_MIN = XW'(-64'sd2147483648);

  // one classified job between front and back
  typedef struct packed {
    logic [NW-1:0]          num_x;
    logic [NW-1:0]          num_y;
    logic [GW-1:0]          den;
    logic                   neg_x;
    logic                   neg_y;
    logic                   colin;
    logic signed [CW-1:0]   ax;
    logic signed [CW-1:0]   ay;
  } job_t;

endpackage
`default_nettype wire

>>> design/ccr_fifo.sv
`default_nettype none
module ccr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [0:DEPTH-1];
  logic [AW-1:0]    wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNTW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rptr_r];

  // pointer and fill count update
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

>>> design/ccr_front.sv
`default_nettype none
module ccr_front
  import ccr_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  output logic                     full,
  input  wire logic signed [CW-1:0] in_ax,
  input  wire logic signed [CW-1:0] in_ay,
  input  wire logic signed [CW-1:0] in_bx,
  input  wire logic signed [CW-1:0] in_by,
  input  wire logic signed [CW-1:0] in_cx,
  input  wire logic signed [CW-1:0] in_cy,
  output logic                     job_valid,
  output job_t                     job,
  input  wire logic                job_full
);

  localparam int SW = (COORD_WIDTH < CW) ? COORD_WIDTH : CW;
  localparam int SH = CW - SW;

  logic fe;
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r;

  logic signed [CW-1:0] ax, ay, bx, by, cx, cy;

  logic signed [DW-1:0] s1_da_r, s1_db_r, s1_dc_r, s1_dd_r;
  logic signed [DW-1:0] s1_sabx_r, s1_saby_r, s1_sacx_r, s1_sacy_r;
  logic signed [DW-1:0] s1_ecy_r, s1_ecx_r;
  logic signed [CW-1:0] s1_ax_r, s1_ay_r;

  logic signed [PW-1:0] s2_pe1_r, s2_pe2_r, s2_pf1_r, s2_pf2_r, s2_pg1_r, s2_pg2_r;
  logic signed [DW-1:0] s2_da_r, s2_db_r, s2_dc_r, s2_dd_r;
  logic signed [CW-1:0] s2_ax_r, s2_ay_r;

  logic signed [EW-1:0] s3_e_r, s3_f_r;
  logic signed [GW-1:0] s3_g_r;
  logic                 s3_colin_r;
  logic signed [DW-1:0] s3_da_r, s3_db_r, s3_dc_r, s3_dd_r;
  logic signed [CW-1:0] s3_ax_r, s3_ay_r;

  logic signed [MW-1:0] s4_m1_r, s4_m2_r, s4_m3_r, s4_m4_r;
  logic signed [GW-1:0] s4_g_r;
  logic                 s4_colin_r;
  logic signed [CW-1:0] s4_ax_r, s4_ay_r;

  logic signed [NW-1:0] nx, ny;
  logic signed [EW-1:0] gd;
  job_t                 s5_job_r;

  // the whole front advances unless the last stage is blocked by a full queue
  assign fe        = !s5_vld_r || !job_full;
  assign full      = !fe;
  assign job_valid = s5_vld_r;
  assign job       = s5_job_r;

  // sign extension at the coordinate width
  assign ax = (in_ax <<< SH) >>> SH;
  assign ay = (in_ay <<< SH) >>> SH;
  assign bx = (in_bx <<< SH) >>> SH;
  assign by = (in_by <<< SH) >>> SH;
  assign cx = (in_cx <<< SH) >>> SH;
  assign cy = (in_cy <<< SH) >>> SH;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else if (fe) begin
      s1_vld_r <= push;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
    end
  end

  // numerators and magnitudes for the last stage
  assign nx = NW'(s4_m1_r) - NW'(s4_m2_r);
  assign ny = NW'(s4_m3_r) - NW'(s4_m4_r);
  assign gd = '0;

  always_ff @(posedge clk) begin
    if (fe) begin
      // differences and sums
      s1_da_r   <= DW'(bx) - DW'(ax);
      s1_db_r   <= DW'(by) - DW'(ay);
      s1_dc_r   <= DW'(cx) - DW'(ax);
      s1_dd_r   <= DW'(cy) - DW'(ay);
      s1_sabx_r <= DW'(ax) + DW'(bx);
      s1_saby_r <= DW'(ay) + DW'(by);
      s1_sacx_r <= DW'(ax) + DW'(cx);
      s1_sacy_r <= DW'(ay) + DW'(cy);
      s1_ecy_r  <= DW'(cy) - DW'(by);
      s1_ecx_r  <= DW'(cx) - DW'(bx);
      s1_ax_r   <= ax;
      s1_ay_r   <= ay;

      // first products
      s2_pe1_r <= s1_da_r * s1_sabx_r;
      s2_pe2_r <= s1_db_r * s1_saby_r;
      s2_pf1_r <= s1_dc_r * s1_sacx_r;
      s2_pf2_r <= s1_dd_r * s1_sacy_r;
      s2_pg1_r <= s1_da_r * s1_ecy_r;
      s2_pg2_r <= s1_db_r * s1_ecx_r;
      s2_da_r  <= s1_da_r;
      s2_db_r  <= s1_db_r;
      s2_dc_r  <= s1_dc_r;
      s2_dd_r  <= s1_dd_r;
      s2_ax_r  <= s1_ax_r;
      s2_ay_r  <= s1_ay_r;

      // e, f, g and collinear check
      s3_e_r     <= EW'(s2_pe1_r) + EW'(s2_pe2_r);
      s3_f_r     <= EW'(s2_pf1_r) + EW'(s2_pf2_r);
      s3_g_r     <= {EW'(s2_pg1_r) - EW'(s2_pg2_r) + gd, 1'b0};
      s3_colin_r <= (s2_pg1_r == s2_pg2_r);
      s3_da_r    <= s2_da_r;
      s3_db_r    <= s2_db_r;
      s3_dc_r    <= s2_dc_r;
      s3_dd_r    <= s2_dd_r;
      s3_ax_r    <= s2_ax_r;
      s3_ay_r    <= s2_ay_r;

      // second products
      s4_m1_r    <= s3_dd_r * s3_e_r;
      s4_m2_r    <= s3_db_r * s3_f_r;
      s4_m3_r    <= s3_da_r * s3_f_r;
      s4_m4_r    <= s3_dc_r * s3_e_r;
      s4_g_r     <= s3_g_r;
      s4_colin_r <= s3_colin_r;
      s4_ax_r    <= s3_ax_r;
      s4_ay_r    <= s3_ay_r;

      // magnitudes and quotient signs
      s5_job_r.num_x <= nx[NW-1] ? NW'(-nx) : NW'(nx);
      s5_job_r.num_y <= ny[NW-1] ? NW'(-ny) : NW'(ny);
      s5_job_r.den   <= s4_g_r[GW-1] ? GW'(-s4_g_r) : GW'(s4_g_r);
      s5_job_r.neg_x <= nx[NW-1] ^ s4_g_r[GW-1];
      s5_job_r.neg_y <= ny[NW-1] ^ s4_g_r[GW-1];
      s5_job_r.colin <= s4_colin_r;
      s5_job_r.ax    <= s4_ax_r;
      s5_job_r.ay    <= s4_ay_r;
    end
  end

endmodule
`default_nettype wire

>>> design/ccr_div.sv
`default_nettype none
module ccr_div #(
  parameter int NUM_W = 53,
  parameter int DEN_W = 36,
  parameter int TAG_W = 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [NUM_W-1:0] in_num,
  input  wire logic [DEN_W-1:0] in_den,
  input  wire logic [TAG_W-1:0] in_tag,
  output logic                  out_valid,
  output logic [NUM_W-1:0]      out_quo,
  output logic [TAG_W-1:0]      out_tag
);

  // restoring division, one quotient bit per stage
  logic             vld_r [0:NUM_W];
  logic [DEN_W-1:0] rem_r [0:NUM_W];
  logic [NUM_W-1:0] nq_r  [0:NUM_W];
  logic [DEN_W-1:0] den_r [0:NUM_W];
  logic [TAG_W-1:0] tag_r [0:NUM_W];

  // input capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      nq_r[0]  <= in_num;
      den_r[0] <= in_den;
      tag_r[0] <= in_tag;
    end
  end

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W:0] sh, diff;
    logic           ge;

    // shift in the next numerator bit and trial subtract
    assign sh   = {rem_r[k], nq_r[k][NUM_W-1]};
    assign ge   = (sh >= {1'b0, den_r[k]});
    assign diff = sh - {1'b0, den_r[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
        nq_r[k+1]  <= {nq_r[k][NUM_W-2:0], ge};
        den_r[k+1] <= den_r[k];
        tag_r[k+1] <= tag_r[k];
      end
    end
  end

  assign out_valid = vld_r[NUM_W];
  assign out_quo   = nq_r[NUM_W];
  assign out_tag   = tag_r[NUM_W];

endmodule
`default_nettype wire

>>> design/ccr_sqrt.sv
`default_nettype none
module ccr_sqrt #(
  parameter int ROOT_W = 32,
  parameter int TAG_W  = 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire logic [2*ROOT_W-1:0] in_val,
  input  wire logic [TAG_W-1:0]    in_tag,
  output logic                     out_valid,
  output logic [ROOT_W-1:0]        out_root,
  output logic [TAG_W-1:0]         out_tag
);

  localparam int VW = 2 * ROOT_W;
  localparam int MW = ROOT_W + 2;

  // restoring square root, one root bit per stage
  logic              vld_r  [0:ROOT_W];
  logic [MW-1:0]     rem_r  [0:ROOT_W];
  logic [ROOT_W-1:0] root_r [0:ROOT_W];
  logic [VW-1:0]     val_r  [0:ROOT_W];
  logic [TAG_W-1:0]  tag_r  [0:ROOT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      val_r[0]  <= in_val;
      tag_r[0]  <= in_tag;
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [MW+1:0] sh, trial, diff;
    logic          ge;

    // bring down two bits and try root*4+1
    assign sh    = {rem_r[k], val_r[k][VW-1 -: 2]};
    assign trial = {2'b00, root_r[k], 2'b01};
    assign ge    = (sh >= trial);
    assign diff  = sh - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge ? diff[MW-1:0] : sh[MW-1:0];
        root_r[k+1] <= {root_r[k][ROOT_W-2:0], ge};
        val_r[k+1]  <= {val_r[k][VW-3:0], 2'b00};
        tag_r[k+1]  <= tag_r[k];
      end
    end
  end

  assign out_valid = vld_r[ROOT_W];
  assign out_root  = root_r[ROOT_W];
  assign out_tag   = tag_r[ROOT_W];

endmodule
`default_nettype wire

>>> design/ccr_back.sv
`default_nettype none
module ccr_back
  import ccr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                job_valid,
  input  wire job_t                job,
  output logic                     job_pop,
  output logic                     empty,
  input  wire logic                pop,
  output logic signed [RW-1:0]     out_center_x,
  output logic signed [RW-1:0]     out_center_y,
  output logic [RW-1:0]            out_radius,
  output logic [1:0]               out_status
);

  localparam int TXW = 2 + CW;
  localparam int TYW = 1 + CW;
  localparam int TSW = 2 * RW + 3;

  logic en;

  logic           dx_vld, dy_vld;
  logic [NW-1:0]  qx, qy;
  logic [TXW-1:0] tx_in, tx_out;
  logic [TYW-1:0] ty_in, ty_out;

  logic                 d_neg_x, d_neg_y, d_colin;
  logic signed [CW-1:0] d_ax, d_ay;
  logic signed [XW-1:0] px, py, ofs_x, ofs_y;
  logic [XW-1:0]        mx, my;

  logic          p1_vld_r, p1_big_r, p1_sat_r, p1_colin_r;
  logic [RW-1:0] p1_cx_r, p1_cy_r, p1_mx_r, p1_my_r;

  logic            p2_vld_r, p2_big_r, p2_sat_r, p2_colin_r;
  logic [RW-1:0]   p2_cx_r, p2_cy_r;
  logic [2*RW-1:0] p2_sqx_r, p2_sqy_r;

  logic            p3_vld_r, p3_ovf_r, p3_sat_r, p3_colin_r;
  logic [RW-1:0]   p3_cx_r, p3_cy_r;
  logic [2*RW-1:0] p3_sum_r;
  logic [2*RW:0]   sum;

  logic           sq_vld;
  logic [RW-1:0]  root;
  logic [TSW-1:0] ts_in, ts_out;
  logic [RW-1:0]  s_cx, s_cy;
  logic           s_ovf, s_sat, s_colin;

  logic                 out_vld_r;
  logic signed [RW-1:0] out_cx_r, out_cy_r;
  logic [RW-1:0]        out_rad_r;
  logic [1:0]           out_st_r;

  // every back stage moves together unless the result register is held
  assign en      = !out_vld_r || pop;
  assign job_pop = job_valid && en;

  // center divisions
  assign tx_in = {job.neg_x, job.colin, job.ax};
  assign ty_in = {job.neg_y, job.ay};

  ccr_div #(.NUM_W(NW), .DEN_W(GW), .TAG_W(TXW)) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (job_valid),
    .in_num   (job.num_x),
    .in_den   (job.den),
    .in_tag   (tx_in),
    .out_valid(dx_vld),
    .out_quo  (qx),
    .out_tag  (tx_out)
  );

  ccr_div #(.NUM_W(NW), .DEN_W(GW), .TAG_W(TYW)) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (job_valid),
    .in_num   (job.num_y),
    .in_den   (job.den),
    .in_tag   (ty_in),
    .out_valid(dy_vld),
    .out_quo  (qy),
    .out_tag  (ty_out)
  );

  // signed center, offset from the first point, clamping
  assign {d_neg_x, d_colin, d_ax} = tx_out;
  assign {d_neg_y, d_ay}          = ty_out;

  assign px    = d_neg_x ? -$signed({2'b00, qx}) : $signed({2'b00, qx});
  assign py    = d_neg_y ? -$signed({2'b00, qy}) : $signed({2'b00, qy});
  assign ofs_x = XW'(d_ax) - px;
  assign ofs_y = XW'(d_ay) - py;
  assign mx    = ofs_x[XW-1] ? XW'(-ofs_x) : XW'(ofs_x);
  assign my    = ofs_y[XW-1] ? XW'(-ofs_y) : XW'(ofs_y);

  always_ff @(posedge clk) begin
    if (en) begin
      p1_cx_r    <= (px > S32_MAX) ? 32'h7fff_ffff :
                    (px < S32_MIN) ? 32'h8000_0000 : px[RW-1:0];
      p1_cy_r    <= (py > S32_MAX) ? 32'h7fff_ffff :
                    (py < S32_MIN) ? 32'h8000_0000 : py[RW-1:0];
      p1_sat_r   <= (px > S32_MAX) || (px < S32_MIN) || (py > S32_MAX) || (py < S32_MIN);
      p1_mx_r    <= mx[RW-1:0];
      p1_my_r    <= my[RW-1:0];
      p1_big_r   <= (|mx[XW-1:RW]) || (|my[XW-1:RW]);
      p1_colin_r <= d_colin;
    end
  end

  // squares of the offsets
  always_ff @(posedge clk) begin
    if (en) begin
      p2_sqx_r   <= p1_mx_r * p1_mx_r;
      p2_sqy_r   <= p1_my_r * p1_my_r;
      p2_cx_r    <= p1_cx_r;
      p2_cy_r    <= p1_cy_r;
      p2_big_r   <= p1_big_r;
      p2_sat_r   <= p1_sat_r;
      p2_colin_r <= p1_colin_r;
    end
  end

  // sum of squares; a carry out or an oversized offset flags overflow
  assign sum = {1'b0, p2_sqx_r} + {1'b0, p2_sqy_r};

  always_ff @(posedge clk) begin
    if (en) begin
      p3_sum_r   <= sum[2*RW-1:0];
      p3_ovf_r   <= sum[2*RW] || p2_big_r;
      p3_cx_r    <= p2_cx_r;
      p3_cy_r    <= p2_cy_r;
      p3_sat_r   <= p2_sat_r;
      p3_colin_r <= p2_colin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
      p3_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r <= dx_vld && dy_vld;
      p2_vld_r <= p1_vld_r;
      p3_vld_r <= p2_vld_r;
    end
  end

  // radius
  assign ts_in = {p3_cx_r, p3_cy_r, p3_ovf_r, p3_sat_r, p3_colin_r};

  ccr_sqrt #(.ROOT_W(RW), .TAG_W(TSW)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (p3_vld_r),
    .in_val   (p3_sum_r),
    .in_tag   (ts_in),
    .out_valid(sq_vld),
    .out_root (root),
    .out_tag  (ts_out)
  );

  assign {s_cx, s_cy, s_ovf, s_sat, s_colin} = ts_out;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s_colin) begin
        out_cx_r  <= '0;
        out_cy_r  <= '0;
        out_rad_r <= '0;
        out_st_r  <= ST_COLIN;
      end else begin
        out_cx_r  <= $signed(s_cx);
        out_cy_r  <= $signed(s_cy);
        out_rad_r <= s_ovf ? '1 : root;
        out_st_r  <= (s_ovf || s_sat) ? ST_SAT : ST_OK;
      end
    end
  end

  assign empty        = !out_vld_r;
  assign out_center_x = out_cx_r;
  assign out_center_y = out_cy_r;
  assign out_radius   = out_rad_r;
  assign out_status   = out_st_r;

endmodule
`default_nettype wire

>>> design/circumcircle_center_radius.sv
// throughput: one item per cycle unless held by a full queue or an unpopped result;
//   the restoring divider (one quotient bit a stage) and the square root
//   (one root bit a stage) are fully pipelined
// a four-entry job queue separates the front arithmetic from the back pipeline
// reset: synchronous active-low rst_n clears valid bits, queue pointers and queue fill count only
`default_nettype none
module circumcircle_center_radius
  import ccr_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic signed [CW-1:0] in_ax,
  input  wire logic signed [CW-1:0] in_ay,
  input  wire logic signed [CW-1:0] in_bx,
  input  wire logic signed [CW-1:0] in_by,
  input  wire logic signed [CW-1:0] in_cx,
  input  wire logic signed [CW-1:0] in_cy,
  output logic                      empty,
  input  wire logic                 pop,
  output logic signed [RW-1:0]      out_center_x,
  output logic signed [RW-1:0]      out_center_y,
  output logic [RW-1:0]             out_radius,
  output logic [1:0]                out_status
);

  logic f_valid, q_full, q_empty, q_pop;
  job_t f_job, q_job;

  // front: differences, determinant, numerators
  ccr_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_ax    (in_ax),
    .in_ay    (in_ay),
    .in_bx    (in_bx),
    .in_by    (in_by),
    .in_cx    (in_cx),
    .in_cy    (in_cy),
    .job_valid(f_valid),
    .job      (f_job),
    .job_full (q_full)
  );

  // job queue
  ccr_fifo #(.WIDTH($bits(job_t)), .DEPTH(QDEPTH)) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (f_valid),
    .wr_data(f_job),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd_data(q_job),
    .empty  (q_empty)
  );

  // back: division, radius, result register
  ccr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .job_valid   (!q_empty),
    .job         (q_job),
    .job_pop     (q_pop),
    .empty       (empty),
    .pop         (pop),
    .out_center_x(out_center_x),
    .out_center_y(out_center_y),
    .out_radius  (out_radius),
    .out_status  (out_status)
  );

endmodule
`default_nettype wire

>>> design/ccr_check.sv
`default_nettype none
module ccr_check
  import ccr_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 push,
  input wire logic                 full,
  input wire logic signed [CW-1:0] in_ax,
  input wire logic signed [CW-1:0] in_ay,
  input wire logic signed [CW-1:0] in_bx,
  input wire logic signed [CW-1:0] in_by,
  input wire logic signed [CW-1:0] in_cx,
  input wire logic signed [CW-1:0] in_cy,
  input wire logic                 empty,
  input wire logic                 pop,
  input wire logic signed [RW-1:0] out_center_x,
  input wire logic signed [RW-1:0] out_center_y,
  input wire logic [RW-1:0]        out_radius,
  input wire logic [1:0]           out_status
);

  // reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result present after reset");

  // a waiting result holds until its transfer
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_center_x) && $stable(out_center_y)
      && $stable(out_radius) && $stable(out_status))
    else $error("result changed while stalled");

  // collinear results carry zero fields
  a_colin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_status == ST_COLIN |->
      out_center_x == 0 && out_center_y == 0 && out_radius == 0)
    else $error("collinear result not zeroed");

  // status code three never appears
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_status == ST_OK || out_status == ST_COLIN || out_status == ST_SAT)
    else $error("bad status code");

endmodule

bind circumcircle_center_radius ccr_check u_check (.*);
`default_nettype wire
